// File: design/kdkf_pkg.sv
// Shared constants and types for the keypad debounce and key queue unit.
// No dependencies; imported by the controller, the datapath and the top level.
package kdkf_pkg;

  localparam int unsigned CNT_W  = 8;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned WAIT_W = 4;
  localparam int unsigned ROW_W  = 2;
  localparam int unsigned COL_W  = 2;

  localparam logic [CNT_W-1:0]  COUNTER_MAX  = 8'd255;
  localparam logic [CNT_W-1:0]  STABLE_RESET = 8'd4;
  localparam logic [WAIT_W-1:0] WAIT_MAX     = 4'd15;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef struct packed {
    logic capture;
    logic commit;
  } kdkf_cmd_t;

  typedef struct packed {
    logic out_free;
  } kdkf_status_t;

endpackage

// File: design/kdkf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kdkf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/kdkf_ctrl.sv
// Controller: two-state sequencer that accepts a request, then commits it.
// Depends on kdkf_pkg.
module kdkf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  kdkf_pkg::kdkf_status_t status_i,
  output logic                  in_ready_o,
  output kdkf_pkg::kdkf_cmd_t   cmd_o
);
  import kdkf_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   ready_q;

  assign cmd_o.capture = in_valid_i && ready_q;
  assign cmd_o.commit  = (state_q == ST_EXEC) && status_i.out_free;
  assign in_ready_o    = ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.capture) begin
            state_q <= ST_EXEC;
            ready_q <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (cmd_o.commit) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_capture_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !ready_q && state_q == ST_EXEC) else $error("capture not held");
  a_wait_for_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC && !status_i.out_free |=> state_q == ST_EXEC)
    else $error("left exec without output slot");

endmodule

// File: design/kdkf_datapath.sv
// Datapath: request registers, press counter RAM with valid bits, key queue RAM,
// ring pointers, threshold register and output register. Depends on kdkf_pkg, kdkf_ram.
module kdkf_datapath #(
  parameter int unsigned ROWS        = 4,
  parameter int unsigned COLS        = 4,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  kdkf_pkg::kdkf_cmd_t               cmd_i,
  output kdkf_pkg::kdkf_status_t            status_o,
  input  logic                              cfg_we_i,
  input  logic [kdkf_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic                              opcode_i,
  input  logic [kdkf_pkg::ROW_W-1:0]        row_i,
  input  logic [kdkf_pkg::COL_W-1:0]        col_i,
  input  logic                              level_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [kdkf_pkg::OUT_DATA_W-1:0]   out_data_o
);
  import kdkf_pkg::*;

  localparam int unsigned KEY_COUNT = ROWS * COLS;
  localparam int unsigned IDX_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned FULL_W    = $clog2(4 * COLS) + 1;
  localparam int unsigned RC_W      = 5;
  localparam int unsigned PW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW        = PW + 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  // request capture
  logic [FULL_W-1:0] full_idx;
  logic              in_range;
  logic              op_q, level_q, in_range_q, hit_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CODE_W-1:0] code_in_q;

  assign full_idx = FULL_W'(row_i) * FULL_W'(COLS) + FULL_W'(col_i);
  assign in_range = (RC_W'(row_i) < RC_W'(ROWS)) && (RC_W'(col_i) < RC_W'(COLS));

  logic [KEY_COUNT-1:0] cnt_vld_q;
  logic [CNT_W-1:0]     stable_q;
  logic [PW-1:0]        rd_ptr_q, wr_ptr_q, rd_ptr_d, wr_ptr_d;
  logic                 out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= opcode_i;
      level_q    <= level_i;
      in_range_q <= in_range;
      idx_q      <= IDX_W'(full_idx);
      code_in_q  <= CODE_W'(full_idx);
      hit_q      <= in_range && cnt_vld_q[IDX_W'(full_idx)];
    end
  end

  // storage
  logic             cnt_we;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
  logic             q_push;
  logic [CODE_W-1:0] q_rdata;

  kdkf_ram #(.WIDTH(CNT_W), .DEPTH(KEY_COUNT), .AW(IDX_W)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we && cmd_i.commit),
    .waddr_i (idx_q),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (IDX_W'(full_idx)),
    .rdata_o (cnt_rdata)
  );

  kdkf_ram #(.WIDTH(CODE_W), .DEPTH(QUEUE_DEPTH), .AW(PW)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_push && cmd_i.commit),
    .waddr_i (wr_ptr_q),
    .wdata_i (code_in_q),
    .re_i    (cmd_i.capture),
    .raddr_i (rd_ptr_q),
    .rdata_o (q_rdata)
  );

  // execute
  logic [CNT_W-1:0]  cnt_cur, cnt_inc;
  logic [PW-1:0]     rd_next, wr_next;
  logic              key_valid, dropped;
  logic [CODE_W-1:0] key_code;
  logic [FW-1:0]     fill;
  logic [WAIT_W-1:0] waiting;

  assign cnt_cur = hit_q ? cnt_rdata : '0;
  assign cnt_inc = cnt_cur + CNT_W'(1);
  assign rd_next = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
  assign wr_next = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);

  always_comb begin
    cnt_we    = 1'b0;
    cnt_wdata = '0;
    q_push    = 1'b0;
    dropped   = 1'b0;
    key_valid = 1'b0;
    key_code  = '0;
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    if (op_q == OP_POP) begin
      if (rd_ptr_q != wr_ptr_q) begin
        key_valid = 1'b1;
        key_code  = q_rdata;
        rd_ptr_d  = rd_next;
      end
    end else if (in_range_q) begin
      if (!level_q) begin
        if (cnt_cur != COUNTER_MAX) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_inc;
          if (cnt_inc == stable_q) begin
            if (wr_next != rd_ptr_q) begin
              q_push   = 1'b1;
              wr_ptr_d = wr_next;
            end else begin
              dropped = 1'b1;
            end
          end
        end
      end else begin
        cnt_we = 1'b1;
      end
    end
  end

  always_comb begin
    if (wr_ptr_d >= rd_ptr_d) begin
      fill = FW'(wr_ptr_d) - FW'(rd_ptr_d);
    end else begin
      fill = FW'(wr_ptr_d) + FW'(QUEUE_DEPTH) - FW'(rd_ptr_d);
    end
  end

  assign waiting = (FW'(fill) > FW'(WAIT_MAX)) ? WAIT_MAX : WAIT_W'(fill);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q   <= '0;
      stable_q    <= STABLE_RESET;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        stable_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        rd_ptr_q    <= rd_ptr_d;
        wr_ptr_q    <= wr_ptr_d;
        out_valid_q <= 1'b1;
        if (cnt_we) begin
          cnt_vld_q[idx_q] <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {(OUT_DATA_W - WAIT_W - CODE_W - 3)'(0), waiting, dropped,
                     q_push, key_code, key_valid};
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && q_push |=> wr_ptr_q != rd_ptr_q) else $error("push left queue empty");
  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> rd_ptr_q == $past(rd_ptr_q) && wr_ptr_q == $past(wr_ptr_q))
    else $error("pointer moved without commit");
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q) else $error("committed result not shown");
  a_pop_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && key_valid |=> rd_ptr_q != $past(rd_ptr_q))
    else $error("pop did not advance");

endmodule

// File: design/keypad_debounce_key_fifo_unit.sv
// Keypad debounce with key queue: one request (key sample or pop) yields one result.
// Accepting a request reads the counter and queue RAMs; execute then commits the result
// to the output register once the output slot is free. A new request is not taken until
// the last one is committed; a waiting result holds execute and stalls intake.
// Reset: counters read as zero through per-key valid bits, queue empty, threshold 4.
// Depends on kdkf_pkg, kdkf_ctrl, kdkf_datapath, kdkf_ram.
module keypad_debounce_key_fifo_unit #(
  parameter int unsigned ROWS        = 4,
  parameter int unsigned COLS        = 4,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kdkf_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // row_index[1:0], col_index[3:2], pin_level[4], zero fill
  input  logic [kdkf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // opcode[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // key_valid[0], key_code[4:1], queued[5], dropped[6], waiting_count[10:7], zero fill
  output logic [kdkf_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import kdkf_pkg::*;

  kdkf_cmd_t    cmd;
  kdkf_status_t status;

  kdkf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  kdkf_datapath #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .opcode_i    (s_axis_tuser),
    .row_i       (s_axis_tdata[1:0]),
    .col_i       (s_axis_tdata[3:2]),
    .level_i     (s_axis_tdata[4]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
